FILE: hdl/tccq_pkg.sv
package tccq_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_BITS    = 16;

   // Working widths
   localparam int VEC_W      = 52;              // vectoring datapath
   localparam int ROT_W      = 32;              // sin/cos in Q30
   localparam int ROT_ZW     = ANGLE_BITS + 2;  // rotation angle, holds the half-angle scale
   localparam int SQRT_STEPS = 24;              // one root bit per stage
   localparam int SQRT_W     = 48;
   localparam int PROD_W     = 48;              // 16-bit sample times Q30

   typedef logic signed [15:0]         s16_type;
   typedef logic signed [ANGLE_BITS-1:0] ang_type;
   typedef logic signed [VEC_W-1:0]    vec_word_type;
   typedef logic signed [ROT_W-1:0]    rot_word_type;
   typedef logic signed [ROT_ZW-1:0]   rot_ang_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [PROD_W:0]     mxc_type;
   typedef logic signed [PROD_W+1:0]   myc_type;
   typedef logic signed [ROT_W+1:0]    qsum_type;
   typedef logic [SQRT_W-1:0]          sq_type;

   typedef struct packed {
      vec_word_type x;
      vec_word_type y;
      ang_type      z;
      logic         zero;
   } vec_type;

   typedef struct packed {
      rot_word_type x;
      rot_word_type y;
      rot_ang_type  z;
      logic         neg;
   } rot_type;

   localparam rot_word_type KINV_Q30    = 32'sd652032874;
   localparam ang_type      ANG_QUARTER = ang_type'(2 ** (ANGLE_BITS - 2));

   localparam int ANG_UP  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
   localparam int ANG_DN  = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
   localparam int ANG_RND = (1 << ANG_DN) >> 1;

   // atan(2^-i) with 2^32 per turn
   localparam logic [31:0] ATAN_TURN32 [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   function automatic logic [32:0] step_angle(int i, int bits);
      logic [32:0] t;
      t = {1'b0, ATAN_TURN32[i % 24]} + (33'd1 << (31 - bits));
      return t >> (32 - bits);
   endfunction

   function automatic vec_type vec_init(vec_word_type y, vec_word_type x);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = ANG_QUARTER;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -ANG_QUARTER;
         end
      end else begin
         v.x = x;
         v.y = y;
         v.z = '0;
      end
      return v;
   endfunction

   function automatic vec_type vec_step(vec_type v, int i);
      vec_word_type x, y, dx, dy;
      ang_type      z, st;
      vec_type      r;
      x  = v.x;
      y  = v.y;
      z  = v.z;
      dx = y >>> i;
      dy = x >>> i;
      st = ang_type'(step_angle(i, ANGLE_BITS));
      if (y >= 0) begin
         r.x = x + dx;
         r.y = y - dy;
         r.z = z + st;
      end else begin
         r.x = x - dx;
         r.y = y + dy;
         r.z = z - st;
      end
      r.zero = v.zero;
      return r;
   endfunction

   function automatic ang_type vec_angle(vec_type v);
      return v.zero ? ang_type'(0) : v.z;
   endfunction

   function automatic rot_type rot_init(ang_type a, int bits);
      rot_ang_type z, half, quarter;
      rot_type     r;
      z       = rot_ang_type'(a);
      half    = rot_ang_type'(1) << (bits - 1);
      quarter = rot_ang_type'(1) << (bits - 2);
      r.x     = KINV_Q30;
      r.y     = '0;
      r.neg   = 1'b0;
      r.z     = z;
      if (z > quarter) begin
         r.z   = z - half;
         r.neg = 1'b1;
      end else if (z < -quarter) begin
         r.z   = z + half;
         r.neg = 1'b1;
      end
      return r;
   endfunction

   function automatic rot_type rot_step(rot_type v, int i, int bits);
      rot_word_type x, y, dx, dy;
      rot_ang_type  z, st;
      rot_type      r;
      x  = v.x;
      y  = v.y;
      z  = v.z;
      dx = y >>> i;
      dy = x >>> i;
      st = rot_ang_type'(step_angle(i, bits));
      if (z >= 0) begin
         r.x = x - dx;
         r.y = y + dy;
         r.z = z - st;
      end else begin
         r.x = x + dx;
         r.y = y - dy;
         r.z = z + st;
      end
      r.neg = v.neg;
      return r;
   endfunction

   function automatic rot_word_type rot_cos(rot_type v);
      rot_word_type x;
      x = v.x;
      return v.neg ? -x : x;
   endfunction

   function automatic rot_word_type rot_sin(rot_type v);
      rot_word_type y;
      y = v.y;
      return v.neg ? -y : y;
   endfunction

   function automatic rot_word_type p30(rot_word_type a, rot_word_type b);
      logic signed [2*ROT_W-1:0] m;
      m = a * b;
      m = m + (64'sd1 <<< 29);
      return rot_word_type'(m >>> 30);
   endfunction

   function automatic logic [15:0] angle_out(ang_type a);
      logic signed [ANGLE_BITS+16:0] w;
      w = (ANGLE_BITS+17)'(a);
      if (ANGLE_BITS > 16)
         w = (w + ANG_RND) >>> ANG_DN;
      else
         w = w <<< ANG_UP;
      return w[15:0];
   endfunction

   function automatic logic [15:0] quat_out(rot_word_type a, rot_word_type b, logic sub);
      qsum_type v;
      v = sub ? (qsum_type'(a) - qsum_type'(b)) : (qsum_type'(a) + qsum_type'(b));
      v = (v + qsum_type'(32768)) >>> 16;
      if (v > qsum_type'(16384))
         return 16'sd16384;
      if (v < -qsum_type'(16384))
         return -16'sd16384;
      return v[15:0];
   endfunction

endpackage

FILE: hdl/tilt_compensated_compass_quaternion_unit.sv
// Tilt-compensated compass: each req beat carries one raw accelerometer and magnetometer
// sample, each rsp beat the roll, pitch and yaw binary angles (32768 = pi) and the ZYX
// quaternion in Q2.14 saturated to +-16384. The unit is a single pipeline that takes one
// beat per clock while rsp is not stalled; it is built from the 24-step square root, with
// 16 CORDIC stages by default in the pitch, sin/cos and yaw CORDIC chains, and the
// multiplier stages. A stalled rsp beat holds the whole pipeline.
module tilt_compensated_compass_quaternion_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata    // roll, pitch, yaw, quat_w, quat_x, quat_y, quat_z
);
   import tccq_pkg::*;

   localparam int NS  = CORDIC_STAGES;
   localparam int LAT = SQRT_STEPS + 1 + 4 * (NS + 1) + 4;

   typedef struct packed {
      vec_type roll;
      sq_type  sq_n;
      sq_type  sq_r;
      s16_type ax;
      s16_type mx;
      s16_type my;
      s16_type mz;
   } a_type;

   typedef struct packed {
      ang_type roll;
      vec_type pitch;
      rot_type rf;
      rot_type rh;
      s16_type mx;
      s16_type my;
      s16_type mz;
   } b_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      rot_word_type cr;
      rot_word_type sr;
      rot_word_type hcr;
      rot_word_type hsr;
      rot_type      pf;
      rot_type      ph;
      s16_type      mx;
      s16_type      my;
      s16_type      mz;
   } c_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      rot_word_type cr;
      rot_word_type hcr;
      rot_word_type hsr;
      rot_word_type hcp;
      rot_word_type hsp;
      rot_word_type pss;
      rot_word_type psc;
      prod_type     tx1;
      prod_type     tx2;
      s16_type      mx;
      s16_type      my;
      s16_type      mz;
   } d1_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      rot_word_type hcr;
      rot_word_type hsr;
      rot_word_type hcp;
      rot_word_type hsp;
      mxc_type      mxc;
      prod_type     t1;
      prod_type     t2;
      prod_type     t3;
   } d2_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      rot_word_type hcr;
      rot_word_type hsr;
      rot_word_type hcp;
      rot_word_type hsp;
      vec_type      yaw;
   } e_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      ang_type      yaw;
      rot_word_type hcr;
      rot_word_type hsr;
      rot_word_type hcp;
      rot_word_type hsp;
      rot_type      yh;
   } f_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      ang_type      yaw;
      rot_word_type hcy;
      rot_word_type hsy;
      rot_word_type cc;
      rot_word_type ss;
      rot_word_type sc;
      rot_word_type cs;
   } g1_type;

   typedef struct packed {
      ang_type      roll;
      ang_type      pitch;
      ang_type      yaw;
      rot_word_type w1;
      rot_word_type w2;
      rot_word_type x1;
      rot_word_type x2;
      rot_word_type y1;
      rot_word_type y2;
      rot_word_type z1;
      rot_word_type z2;
   } g2_type;

   a_type  a_ff [0:SQRT_STEPS];
   b_type  b_ff [0:NS];
   c_type  c_ff [0:NS];
   e_type  e_ff [0:NS];
   f_type  f_ff [0:NS];
   a_type  a_in;
   b_type  b_in;
   c_type  c_in;
   d1_type d1_ff, d1_in;
   d2_type d2_ff, d2_in;
   e_type  e_in;
   f_type  f_in;
   g1_type g1_ff, g1_in;
   g2_type g2_ff;
   logic [LAT-1:0] vld_ff;
   logic           rsp_tvalid_ff;
   logic [111:0]   rsp_tdata_ff, rsp_tdata_in;
   logic           adv;

   function automatic a_type a_step(a_type v, int k);
      a_type r;
      sq_type bitv, t;
      r    = v;
      bitv = sq_type'(1) << (46 - 2 * k);
      t    = v.sq_r + bitv;
      if (v.sq_n >= t) begin
         r.sq_n = v.sq_n - t;
         r.sq_r = (v.sq_r >> 1) + bitv;
      end else begin
         r.sq_r = v.sq_r >> 1;
      end
      if (k < NS)
         r.roll = vec_step(v.roll, k);
      return r;
   endfunction

   function automatic b_type b_step(b_type v, int k);
      b_type r;
      r       = v;
      r.pitch = vec_step(v.pitch, k);
      r.rf    = rot_step(v.rf, k, ANGLE_BITS);
      r.rh    = rot_step(v.rh, k, ANGLE_BITS + 1);
      return r;
   endfunction

   function automatic c_type c_step(c_type v, int k);
      c_type r;
      r    = v;
      r.pf = rot_step(v.pf, k, ANGLE_BITS);
      r.ph = rot_step(v.ph, k, ANGLE_BITS + 1);
      return r;
   endfunction

   function automatic e_type e_step(e_type v, int k);
      e_type r;
      r     = v;
      r.yaw = vec_step(v.yaw, k);
      return r;
   endfunction

   function automatic f_type f_step(f_type v, int k);
      f_type r;
      r    = v;
      r.yh = rot_step(v.yh, k, ANGLE_BITS + 1);
      return r;
   endfunction

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff        <= {vld_ff[LAT-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[LAT-1];
      end
   end

   // Sample entry: roll operands and the squared magnitude for the pitch denominator
   always_comb begin
      s16_type ax, ay, az;
      logic signed [32:0] ssq;
      ax = req_tdata[15:0];
      ay = req_tdata[31:16];
      az = req_tdata[47:32];
      ssq = ay * ay + az * az;
      a_in.roll = vec_init(vec_word_type'(ay) <<< 8, vec_word_type'(az) <<< 8);
      a_in.sq_n = {ssq[31:0], 16'b0};
      a_in.sq_r = '0;
      a_in.ax   = ax;
      a_in.mx   = req_tdata[63:48];
      a_in.my   = req_tdata[79:64];
      a_in.mz   = req_tdata[95:80];
   end

   always_ff @(posedge clock) if (adv) a_ff[0] <= a_in;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_a
      always_ff @(posedge clock) if (adv) a_ff[k+1] <= a_step(a_ff[k], k);
   end

   always_comb begin
      ang_type roll;
      roll       = vec_angle(a_ff[SQRT_STEPS].roll);
      b_in.roll  = roll;
      b_in.pitch = vec_init(-(vec_word_type'(a_ff[SQRT_STEPS].ax) <<< 8),
                            vec_word_type'(a_ff[SQRT_STEPS].sq_r));
      b_in.rf    = rot_init(roll, ANGLE_BITS);
      b_in.rh    = rot_init(roll, ANGLE_BITS + 1);
      b_in.mx    = a_ff[SQRT_STEPS].mx;
      b_in.my    = a_ff[SQRT_STEPS].my;
      b_in.mz    = a_ff[SQRT_STEPS].mz;
   end

   always_ff @(posedge clock) if (adv) b_ff[0] <= b_in;

   for (genvar k = 0; k < NS; k++) begin : g_b
      always_ff @(posedge clock) if (adv) b_ff[k+1] <= b_step(b_ff[k], k);
   end

   always_comb begin
      ang_type pitch;
      pitch      = vec_angle(b_ff[NS].pitch);
      c_in.roll  = b_ff[NS].roll;
      c_in.pitch = pitch;
      c_in.cr    = rot_cos(b_ff[NS].rf);
      c_in.sr    = rot_sin(b_ff[NS].rf);
      c_in.hcr   = rot_cos(b_ff[NS].rh);
      c_in.hsr   = rot_sin(b_ff[NS].rh);
      c_in.pf    = rot_init(pitch, ANGLE_BITS);
      c_in.ph    = rot_init(pitch, ANGLE_BITS + 1);
      c_in.mx    = b_ff[NS].mx;
      c_in.my    = b_ff[NS].my;
      c_in.mz    = b_ff[NS].mz;
   end

   always_ff @(posedge clock) if (adv) c_ff[0] <= c_in;

   for (genvar k = 0; k < NS; k++) begin : g_c
      always_ff @(posedge clock) if (adv) c_ff[k+1] <= c_step(c_ff[k], k);
   end

   // Tilt compensation, first products
   always_comb begin
      rot_word_type cp, sp, sr;
      s16_type      mx, mz;
      cp = rot_cos(c_ff[NS].pf);
      sp = rot_sin(c_ff[NS].pf);
      sr = c_ff[NS].sr;
      mx = c_ff[NS].mx;
      mz = c_ff[NS].mz;
      d1_in.roll  = c_ff[NS].roll;
      d1_in.pitch = c_ff[NS].pitch;
      d1_in.cr    = c_ff[NS].cr;
      d1_in.hcr   = c_ff[NS].hcr;
      d1_in.hsr   = c_ff[NS].hsr;
      d1_in.hcp   = rot_cos(c_ff[NS].ph);
      d1_in.hsp   = rot_sin(c_ff[NS].ph);
      d1_in.pss   = p30(sr, sp);
      d1_in.psc   = p30(sr, cp);
      d1_in.tx1   = prod_type'(mx) * prod_type'(cp);
      d1_in.tx2   = prod_type'(mz) * prod_type'(sp);
      d1_in.mx    = mx;
      d1_in.my    = c_ff[NS].my;
      d1_in.mz    = mz;
   end

   always_comb begin
      d2_in.roll  = d1_ff.roll;
      d2_in.pitch = d1_ff.pitch;
      d2_in.hcr   = d1_ff.hcr;
      d2_in.hsr   = d1_ff.hsr;
      d2_in.hcp   = d1_ff.hcp;
      d2_in.hsp   = d1_ff.hsp;
      d2_in.mxc   = mxc_type'(d1_ff.tx1) + mxc_type'(d1_ff.tx2);
      d2_in.t1    = prod_type'(d1_ff.mx) * prod_type'(d1_ff.pss);
      d2_in.t2    = prod_type'(d1_ff.my) * prod_type'(d1_ff.cr);
      d2_in.t3    = prod_type'(d1_ff.mz) * prod_type'(d1_ff.psc);
   end

   always_comb begin
      myc_type myc;
      myc        = myc_type'(d2_ff.t1) + myc_type'(d2_ff.t2) - myc_type'(d2_ff.t3);
      e_in.roll  = d2_ff.roll;
      e_in.pitch = d2_ff.pitch;
      e_in.hcr   = d2_ff.hcr;
      e_in.hsr   = d2_ff.hsr;
      e_in.hcp   = d2_ff.hcp;
      e_in.hsp   = d2_ff.hsp;
      e_in.yaw   = vec_init(vec_word_type'(myc), vec_word_type'(d2_ff.mxc));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         e_ff[0] <= e_in;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_e
      always_ff @(posedge clock) if (adv) e_ff[k+1] <= e_step(e_ff[k], k);
   end

   always_comb begin
      ang_type yaw;
      yaw        = vec_angle(e_ff[NS].yaw);
      f_in.roll  = e_ff[NS].roll;
      f_in.pitch = e_ff[NS].pitch;
      f_in.yaw   = yaw;
      f_in.hcr   = e_ff[NS].hcr;
      f_in.hsr   = e_ff[NS].hsr;
      f_in.hcp   = e_ff[NS].hcp;
      f_in.hsp   = e_ff[NS].hsp;
      f_in.yh    = rot_init(yaw, ANGLE_BITS + 1);
   end

   always_ff @(posedge clock) if (adv) f_ff[0] <= f_in;

   for (genvar k = 0; k < NS; k++) begin : g_f
      always_ff @(posedge clock) if (adv) f_ff[k+1] <= f_step(f_ff[k], k);
   end

   // Quaternion: pair products of roll and pitch, then times the yaw half angle
   always_comb begin
      g1_in.roll  = f_ff[NS].roll;
      g1_in.pitch = f_ff[NS].pitch;
      g1_in.yaw   = f_ff[NS].yaw;
      g1_in.hcy   = rot_cos(f_ff[NS].yh);
      g1_in.hsy   = rot_sin(f_ff[NS].yh);
      g1_in.cc    = p30(f_ff[NS].hcr, f_ff[NS].hcp);
      g1_in.ss    = p30(f_ff[NS].hsr, f_ff[NS].hsp);
      g1_in.sc    = p30(f_ff[NS].hsr, f_ff[NS].hcp);
      g1_in.cs    = p30(f_ff[NS].hcr, f_ff[NS].hsp);
   end

   always_comb begin
      rsp_tdata_in = {quat_out(g2_ff.z1, g2_ff.z2, 1'b1),
                      quat_out(g2_ff.y1, g2_ff.y2, 1'b0),
                      quat_out(g2_ff.x1, g2_ff.x2, 1'b1),
                      quat_out(g2_ff.w1, g2_ff.w2, 1'b0),
                      angle_out(g2_ff.yaw),
                      angle_out(g2_ff.pitch),
                      angle_out(g2_ff.roll)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_ff          <= g1_in;
         g2_ff.roll     <= g1_ff.roll;
         g2_ff.pitch    <= g1_ff.pitch;
         g2_ff.yaw      <= g1_ff.yaw;
         g2_ff.w1       <= p30(g1_ff.cc, g1_ff.hcy);
         g2_ff.w2       <= p30(g1_ff.ss, g1_ff.hsy);
         g2_ff.x1       <= p30(g1_ff.sc, g1_ff.hcy);
         g2_ff.x2       <= p30(g1_ff.cs, g1_ff.hsy);
         g2_ff.y1       <= p30(g1_ff.cs, g1_ff.hcy);
         g2_ff.y2       <= p30(g1_ff.sc, g1_ff.hsy);
         g2_ff.z1       <= p30(g1_ff.cc, g1_ff.hsy);
         g2_ff.z2       <= p30(g1_ff.ss, g1_ff.hcy);
         rsp_tdata_ff   <= rsp_tdata_in;
      end
   end

endmodule

FILE: test/tb_tilt_compensated_compass_quaternion_unit.sv
`timescale 1ns / 100ps

module tb_tilt_compensated_compass_quaternion_unit;
   import tccq_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 140;
   localparam int STAGES       = CORDIC_STAGES;
   localparam int ABITS        = ANGLE_BITS;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;   // roll, pitch, yaw, quat_w, quat_x, quat_y, quat_z

   logic [111:0] pose_queue [$];
   int           error_count;
   int           samples_sent;
   int           poses_checked;
   longint       cycle_count;

   tilt_compensated_compass_quaternion_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- pose predictor ----------------
   function automatic longint atan_step(int i, int bits);
      longint t;
      t = longint'(ATAN_TURN32[i % 24]);
      return (t + (64'sd1 <<< (31 - bits))) >>> (32 - bits);
   endfunction

   function automatic longint wrap_to(longint a, int bits);
      longint m, u;
      m = 64'sd1 <<< bits;
      u = a & (m - 1);
      if (u >= (m >>> 1)) u = u - m;
      return u;
   endfunction

   function automatic longint cordic_atan2(longint y, longint x, int bits);
      longint z, t, dx, dy, quarter;
      z = 0;
      quarter = 64'sd1 <<< (bits - 2);
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = quarter;
         end else begin
            x = -y; y = t; z = -quarter;
         end
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + atan_step(i, bits);
         end else begin
            x = x - dx; y = y + dy; z = z - atan_step(i, bits);
         end
      end
      return wrap_to(z, bits);
   endfunction

   function automatic void cordic_sincos(input longint a, input int bits,
                                         output longint c, output longint s);
      longint x, y, z, dx, dy, half, quarter;
      bit     flip;
      half = 64'sd1 <<< (bits - 1);
      quarter = 64'sd1 <<< (bits - 2);
      x = 652032874;
      y = 0;
      z = a;
      flip = 1'b0;
      if (z > quarter) begin
         z = z - half; flip = 1'b1;
      end else if (z < -quarter) begin
         z = z + half; flip = 1'b1;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_step(i, bits);
         end else begin
            x = x + dx; y = y - dy; z = z + atan_step(i, bits);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic logic [15:0] to_bam16(longint a);
      longint o;
      if (ABITS > 16) o = (a + (64'sd1 <<< (ABITS - 17))) >>> (ABITS - 16);
      else o = a * (64'sd1 <<< (16 - ABITS));
      return o[15:0];
   endfunction

   function automatic logic [15:0] to_q14(longint v);
      longint q;
      q = (v + (64'sd1 <<< 15)) >>> 16;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q[15:0];
   endfunction

   function automatic logic [111:0] predict_pose(logic [95:0] d);
      longint ax, ay, az, mx, my, mz;
      longint roll, pitch, yaw, den, mxc, myc;
      longint cr, sr, cp, sp, hcr, hsr, hcp, hsp, hcy, hsy;
      logic [111:0] r;
      ax = longint'(s16_type'(d[15:0]));
      ay = longint'(s16_type'(d[31:16]));
      az = longint'(s16_type'(d[47:32]));
      mx = longint'(s16_type'(d[63:48]));
      my = longint'(s16_type'(d[79:64]));
      mz = longint'(s16_type'(d[95:80]));
      roll = cordic_atan2(ay * 256, az * 256, ABITS);
      den = root_floor(longint'(ay * ay + az * az) * 65536);
      pitch = cordic_atan2(-ax * 256, den, ABITS);
      cordic_sincos(roll, ABITS, cr, sr);
      cordic_sincos(pitch, ABITS, cp, sp);
      mxc = mx * cp + mz * sp;
      myc = mx * mul_q30(sr, sp) + my * cr - mz * mul_q30(sr, cp);
      yaw = cordic_atan2(myc, mxc, ABITS);
      cordic_sincos(roll, ABITS + 1, hcr, hsr);
      cordic_sincos(pitch, ABITS + 1, hcp, hsp);
      cordic_sincos(yaw, ABITS + 1, hcy, hsy);
      r[15:0]    = to_bam16(roll);
      r[31:16]   = to_bam16(pitch);
      r[47:32]   = to_bam16(yaw);
      r[63:48]   = to_q14(mul_q30(mul_q30(hcr, hcp), hcy) + mul_q30(mul_q30(hsr, hsp), hsy));
      r[79:64]   = to_q14(mul_q30(mul_q30(hsr, hcp), hcy) - mul_q30(mul_q30(hcr, hsp), hsy));
      r[95:80]   = to_q14(mul_q30(mul_q30(hcr, hsp), hcy) + mul_q30(mul_q30(hsr, hcp), hsy));
      r[111:96]  = to_q14(mul_q30(mul_q30(hcr, hcp), hsy) - mul_q30(mul_q30(hsr, hsp), hcy));
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %0d expected %0d (beat %0d)", what,
               $signed(got), $signed(want), poses_checked);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_tilt_compensated_compass_quaternion_unit: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic [111:0] want;
      string names [7];
      names = '{"roll", "pitch", "yaw", "quat_w", "quat_x", "quat_y", "quat_z"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_queue.size() == 0) begin
            $display("MISMATCH unexpected rsp beat %h", rsp_tdata);
            error_count++;
         end else begin
            want = pose_queue.pop_front();
            for (int f = 0; f < 7; f++)
               if (rsp_tdata[16*f +: 16] !== want[16*f +: 16])
                  report_mismatch(names[f], rsp_tdata[16*f +: 16], want[16*f +: 16]);
         end
         poses_checked++;
      end
   end

   // Receiver back-pressure: mostly short stalls, a few long, some free runs
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         n = $urandom_range(0, 99);
         rsp_tready <= 1'b1;
         repeat ((n < 30) ? $urandom_range(20, 80) : $urandom_range(1, 6)) @(posedge clock);
         if (n < 85) begin
            rsp_tready <= 1'b0;
            repeat ((n < 80) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic int pick_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 55) return 0;
      if (n < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_sample(logic [15:0] ax, ay, az, mx, my, mz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {mz, my, mx, az, ay, ax};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pose_queue.push_back(predict_pose({mz, my, mx, az, ay, ax}));
      samples_sent++;
   endtask

   function automatic logic [15:0] rand_axis();
      int n;
      n = $urandom_range(0, 9);
      if (n == 0) return 16'h8000;
      if (n == 1) return 16'h7fff;
      if (n == 2) return 16'(int'($urandom_range(0, 8)) - 4);
      if (n < 5) return 16'(int'($urandom_range(0, 4000)) - 2000);
      return 16'($urandom);
   endfunction

   task automatic test_extremes();
      send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
   endtask

   task automatic test_degenerate();
      // zero accel y/z: roll from atan2(0,0)
      send_sample(16'd1000, 16'd0, 16'd0, 16'd300, 16'd200, 16'd100);
      send_sample(16'h8000, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0);
      // zero magnetometer: yaw from atan2(0,0)
      send_sample(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0);
      send_sample(16'd500, 16'd700, 16'd9000, 16'd0, 16'd0, 16'd0);
      // roll of exactly a half turn wraps
      send_sample(16'd0, 16'd0, 16'hc000, 16'd2000, 16'd100, 16'd50);
      send_sample(16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0, 16'd0);
      // level, pointing along +x, -x, +y and -y
      send_sample(16'd0, 16'd0, 16'd16384, 16'd3000, 16'd0, 16'd0);
      send_sample(16'd0, 16'd0, 16'd16384, 16'hf448, 16'd0, 16'd0);
      send_sample(16'd0, 16'd0, 16'd16384, 16'd0, 16'd3000, 16'd0);
      send_sample(16'd0, 16'd0, 16'd16384, 16'd0, 16'hf448, 16'd0);
      // pitch near vertical, then roll of a quarter turn each way
      send_sample(16'd16384, 16'd0, 16'd1, 16'd100, 16'd200, 16'd300);
      send_sample(16'hc000, 16'd1, 16'd0, 16'd100, 16'd200, 16'd300);
      send_sample(16'd0, 16'd16384, 16'd0, 16'd400, 16'hff00, 16'd800);
      send_sample(16'd0, 16'hc000, 16'd0, 16'd400, 16'hff00, 16'd800);
   endtask

   task automatic test_random(int count);
      for (int k = 0; k < count; k++)
         send_sample(rand_axis(), rand_axis(), rand_axis(),
                     rand_axis(), rand_axis(), rand_axis());
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      error_count  = 0;
      samples_sent = 0;
      poses_checked = 0;
      cycle_count  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_degenerate();
      test_random(1600);
      req_tvalid <= 1'b0;

      // drain the pipeline
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples: axis extremes, zero accel and magnetometer, half-turn roll,",
               samples_sent);
      $display("near-vertical pitch and random samples under random stalls; %0d poses checked",
               poses_checked);
      if (error_count == 0 && pose_queue.size() == 0) begin
         $display("tb_tilt_compensated_compass_quaternion_unit: done, clean");
      end else begin
         $display("tb_tilt_compensated_compass_quaternion_unit: done, errors");
      end
      $finish;
   end

endmodule

FILE: tilt_compensated_compass_quaternion_unit.f
hdl/tccq_pkg.sv
hdl/tilt_compensated_compass_quaternion_unit.sv
test/tb_tilt_compensated_compass_quaternion_unit.sv
